FILE: rtl/pdg_pkg.sv
// Shared widths for the point deduplication and global numbering block.
`default_nettype none
package pdg_pkg;
    localparam int IDX_W = 6;   // point index / unique id width
    localparam int CNT_W = 7;   // point count / unique count width
    localparam int TOL_W = 31;  // tolerance register width
endpackage
`default_nettype wire

FILE: rtl/pdg_cell.sv
// One cell of the sorting chain: holds one point, inserts in order, shifts out to the left.
`default_nettype none
module pdg_cell #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     ins_en,
    input  wire logic                     shift_en,
    input  wire logic [COORD_WIDTH-1:0]   new_x,
    input  wire logic [COORD_WIDTH-1:0]   new_z,
    input  wire logic [pdg_pkg::IDX_W-1:0] new_idx,
    input  wire logic [COORD_WIDTH-1:0]   left_x,
    input  wire logic [COORD_WIDTH-1:0]   left_z,
    input  wire logic [pdg_pkg::IDX_W-1:0] left_idx,
    input  wire logic                     left_vld,
    input  wire logic                     left_gt,
    input  wire logic [COORD_WIDTH-1:0]   right_x,
    input  wire logic [COORD_WIDTH-1:0]   right_z,
    input  wire logic [pdg_pkg::IDX_W-1:0] right_idx,
    input  wire logic                     right_vld,
    output logic [COORD_WIDTH-1:0]        key_x,
    output logic [COORD_WIDTH-1:0]        key_z,
    output logic [pdg_pkg::IDX_W-1:0]     key_idx,
    output logic                          key_vld,
    output logic                          gt
);
    logic [COORD_WIDTH-1:0]    x_reg, z_reg;
    logic [pdg_pkg::IDX_W-1:0] idx_reg;
    logic                      vld_reg;
    logic                      new_lt;

    // new point sorts strictly before this one (signed x, then signed z)
    assign new_lt = ($signed(new_x) < $signed(x_reg)) ||
                    ((new_x == x_reg) && ($signed(new_z) < $signed(z_reg)));
    // an empty cell acts as +infinity
    assign gt = !vld_reg || new_lt;

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (shift_en) begin
            vld_reg <= right_vld;
        end else if (ins_en && gt) begin
            vld_reg <= left_gt ? left_vld : 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            x_reg   <= right_x;
            z_reg   <= right_z;
            idx_reg <= right_idx;
        end else if (ins_en && gt) begin
            if (left_gt) begin
                x_reg   <= left_x;
                z_reg   <= left_z;
                idx_reg <= left_idx;
            end else begin
                x_reg   <= new_x;
                z_reg   <= new_z;
                idx_reg <= new_idx;
            end
        end
    end

    assign key_x   = x_reg;
    assign key_z   = z_reg;
    assign key_idx = idx_reg;
    assign key_vld = vld_reg;
endmodule
`default_nettype wire

FILE: rtl/point_dedup_global_numbering_unit.sv
// Flow: points load one per cycle while s_ready is high, into a sorted cell chain
// (insertion on arrival). After the final point the chain shifts out and assigns
// groups, then each point is numbered densely through the group map memory.
// Results: one per point, registered from the point memory read, held until m_ready.
// Reset: control, counters, chain valid bits and group-map valid bits clear;
// memories need no clearing pass.
`default_nettype none
module point_dedup_global_numbering_unit #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [pdg_pkg::TOL_W-1:0]    cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [COORD_WIDTH-1:0]       s_coord_x,
    input  wire logic [COORD_WIDTH-1:0]       s_coord_z,
    input  wire logic                         s_final_point,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [pdg_pkg::IDX_W-1:0]         m_point_index,
    output logic [pdg_pkg::IDX_W-1:0]         m_unique_id,
    output logic [pdg_pkg::CNT_W-1:0]         m_unique_count,
    output logic                              m_points_dropped,
    output logic                              m_run_end
);
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DW   = COORD_WIDTH + 1;
    localparam int CMPW = (DW > pdg_pkg::TOL_W) ? DW : pdg_pkg::TOL_W;
    localparam int IW   = pdg_pkg::IDX_W;
    localparam int CW   = pdg_pkg::CNT_W;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_GROUP = 3'd1;
    localparam logic [2:0] S_D1    = 3'd2;
    localparam logic [2:0] S_D2    = 3'd3;
    localparam logic [2:0] S_D3    = 3'd4;
    localparam logic [2:0] S_E1    = 3'd5;
    localparam logic [2:0] S_E2    = 3'd6;
    localparam logic [2:0] S_E3    = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [pdg_pkg::TOL_W-1:0] tol_reg;
    logic [CW-1:0]            cnt_reg, k_reg, dense_reg, last_idx;
    logic                     ovf_reg;
    logic [IW-1:0]            g_reg, g_cur, grp_reg;
    logic [COORD_WIDTH-1:0]   prev_x_reg, prev_z_reg;
    logic [MAX_POINTS-1:0]    dvalid_reg;
    logic                     s_acc, ins_en, shift_en, k_last;

    // chain wiring
    logic [COORD_WIDTH-1:0]   c_x [MAX_POINTS];
    logic [COORD_WIDTH-1:0]   c_z [MAX_POINTS];
    logic [IW-1:0]            c_idx [MAX_POINTS];
    logic [MAX_POINTS-1:0]    c_vld, c_gt;

    // memories
    logic [IW-1:0]            pm_mem  [MAX_POINTS];
    logic [IW-1:0]            g2d_mem [MAX_POINTS];
    logic [IW-1:0]            pm_rd, g2d_rd;
    logic [AW-1:0]            pm_raddr, pm_waddr;
    logic [IW-1:0]            pm_wdata;
    logic                     pm_we;

    logic [DW-1:0]            dx, dz, ax, az;
    logic                     new_grp;
    logic [IW-1:0]            dense_sel;

    assign s_ready  = (state_reg == S_LOAD);
    assign s_acc    = s_valid && s_ready;
    assign ins_en   = s_acc && (cnt_reg < CW'(MAX_POINTS));
    assign shift_en = (state_reg == S_GROUP);
    assign last_idx = cnt_reg - {{(CW-1){1'b0}}, 1'b1};
    assign k_last   = (k_reg == last_idx);

    // tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    // row of cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
            pdg_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ins_en    (ins_en),
                .shift_en  (shift_en),
                .new_x     (s_coord_x),
                .new_z     (s_coord_z),
                .new_idx   (cnt_reg[IW-1:0]),
                .left_x    ((gi == 0) ? s_coord_x : c_x[(gi == 0) ? 0 : gi-1]),
                .left_z    ((gi == 0) ? s_coord_z : c_z[(gi == 0) ? 0 : gi-1]),
                .left_idx  ((gi == 0) ? cnt_reg[IW-1:0] : c_idx[(gi == 0) ? 0 : gi-1]),
                .left_vld  ((gi == 0) ? 1'b0 : c_vld[(gi == 0) ? 0 : gi-1]),
                .left_gt   ((gi == 0) ? 1'b0 : c_gt[(gi == 0) ? 0 : gi-1]),
                .right_x   ((gi == MAX_POINTS-1) ? c_x[gi] :
                            c_x[(gi == MAX_POINTS-1) ? gi : gi+1]),
                .right_z   ((gi == MAX_POINTS-1) ? c_z[gi] :
                            c_z[(gi == MAX_POINTS-1) ? gi : gi+1]),
                .right_idx ((gi == MAX_POINTS-1) ? c_idx[gi] :
                            c_idx[(gi == MAX_POINTS-1) ? gi : gi+1]),
                .right_vld ((gi == MAX_POINTS-1) ? 1'b0 :
                            c_vld[(gi == MAX_POINTS-1) ? gi : gi+1]),
                .key_x     (c_x[gi]),
                .key_z     (c_z[gi]),
                .key_idx   (c_idx[gi]),
                .key_vld   (c_vld[gi]),
                .gt        (c_gt[gi])
            );
        end
    endgenerate

    // chained grouping on the head of the chain against the previous point
    assign dx = {c_x[0][COORD_WIDTH-1], c_x[0]} - {prev_x_reg[COORD_WIDTH-1], prev_x_reg};
    assign dz = {c_z[0][COORD_WIDTH-1], c_z[0]} - {prev_z_reg[COORD_WIDTH-1], prev_z_reg};
    assign ax = dx[DW-1] ? (~dx + {{(DW-1){1'b0}}, 1'b1}) : dx;
    assign az = dz[DW-1] ? (~dz + {{(DW-1){1'b0}}, 1'b1}) : dz;
    assign new_grp = (CMPW'(ax) > CMPW'(tol_reg)) || (CMPW'(az) > CMPW'(tol_reg));
    assign g_cur = (k_reg == '0) ? '0 : (new_grp ? g_reg + {{(IW-1){1'b0}}, 1'b1} : g_reg);

    // dense id: reuse the map if the group was seen, else take the next one
    assign dense_sel = dvalid_reg[grp_reg[AW-1:0]] ? g2d_rd : dense_reg[IW-1:0];

    // point memory port control
    always_comb begin
        pm_raddr = k_reg[AW-1:0];
        pm_we    = 1'b0;
        pm_waddr = k_reg[AW-1:0];
        pm_wdata = dense_sel;
        case (state_reg)
            S_GROUP: begin
                pm_we    = 1'b1;
                pm_waddr = c_idx[0][AW-1:0];
                pm_wdata = g_cur;
            end
            S_D3: begin
                pm_we = 1'b1;
            end
            default: begin
                pm_we = 1'b0;
            end
        endcase
    end

    // point memory: group per point, then dense id per point
    always_ff @(posedge aclk) begin
        if (pm_we) begin
            pm_mem[pm_waddr] <= pm_wdata;
        end
        pm_rd <= pm_mem[pm_raddr];
    end

    // group to dense id map
    always_ff @(posedge aclk) begin
        if ((state_reg == S_D3) && !dvalid_reg[grp_reg[AW-1:0]]) begin
            g2d_mem[grp_reg[AW-1:0]] <= dense_reg[IW-1:0];
        end
        g2d_rd <= g2d_mem[pm_rd[AW-1:0]];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:  if (s_acc && s_final_point) state_next = S_GROUP;
            S_GROUP: if (k_last) state_next = S_D1;
            S_D1:    state_next = S_D2;
            S_D2:    state_next = S_D3;
            S_D3:    state_next = k_last ? S_E1 : S_D1;
            S_E1:    state_next = S_E2;
            S_E2:    state_next = S_E3;
            S_E3: begin
                if (m_ready) state_next = k_last ? S_LOAD : S_E1;
            end
            default: state_next = S_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            k_reg      <= '0;
            ovf_reg    <= 1'b0;
            dense_reg  <= '0;
            dvalid_reg <= '0;
            m_valid    <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_LOAD: begin
                    if (ins_en) cnt_reg <= cnt_reg + {{(CW-1){1'b0}}, 1'b1};
                    if (s_acc && !ins_en) ovf_reg <= 1'b1;
                    k_reg <= '0;
                end
                S_GROUP: begin
                    k_reg <= k_last ? '0 : k_reg + {{(CW-1){1'b0}}, 1'b1};
                end
                S_D3: begin
                    if (!dvalid_reg[grp_reg[AW-1:0]]) begin
                        dvalid_reg[grp_reg[AW-1:0]] <= 1'b1;
                        dense_reg <= dense_reg + {{(CW-1){1'b0}}, 1'b1};
                    end
                    k_reg <= k_last ? '0 : k_reg + {{(CW-1){1'b0}}, 1'b1};
                end
                S_E2: begin
                    m_valid <= 1'b1;
                end
                S_E3: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        if (k_last) begin
                            cnt_reg    <= '0;
                            ovf_reg    <= 1'b0;
                            dense_reg  <= '0;
                            dvalid_reg <= '0;
                            k_reg      <= '0;
                        end else begin
                            k_reg <= k_reg + {{(CW-1){1'b0}}, 1'b1};
                        end
                    end
                end
                default: begin
                    m_valid <= m_valid;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_GROUP) begin
            prev_x_reg <= c_x[0];
            prev_z_reg <= c_z[0];
            g_reg      <= g_cur;
        end
        if (state_reg == S_D2) begin
            grp_reg <= pm_rd;
        end
        if (state_reg == S_E2) begin
            m_point_index    <= k_reg[IW-1:0];
            m_unique_id      <= pm_rd;
            m_unique_count   <= dense_reg;
            m_points_dropped <= ovf_reg;
            m_run_end        <= k_last;
        end
    end
endmodule
`default_nettype wire
